/* rtl/core/imu_kalman_tilt_filter_unit_assert.svh */
// Assertion helpers for the tilt filter block.
`ifndef IMU_KALMAN_TILT_FILTER_UNIT_ASSERT_SVH
`define IMU_KALMAN_TILT_FILTER_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define IKF_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define IKF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/ikf_pkg.sv */
`default_nettype none
package ikf_pkg;

  localparam int DATA_WIDTH_DEF  = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int CORDIC_STEPS    = 28;
  localparam int TBL_FRAC        = 24;
  localparam int CORDIC_PRESHIFT = 14;
  localparam int CORDIC_XW       = 34;
  localparam int CORDIC_ZW       = 36;
  localparam int ACC_WIDTH       = 16;
  localparam int GYRO_WIDTH      = 32;
  localparam int OUT_WIDTH       = 32;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 32;
  localparam int PERIOD_W        = 17;
  localparam int NOISE_W         = 31;

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_Q   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_Q    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MEASURE_R = 3'd3;

  localparam logic [PERIOD_W-1:0] PERIOD_RST    = 17'd655;
  localparam logic [NOISE_W-1:0]  ANGLE_Q_RST   = 31'd66;
  localparam logic [NOISE_W-1:0]  BIAS_Q_RST    = 31'd197;
  localparam logic [NOISE_W-1:0]  MEASURE_R_RST = 31'd1966;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORDIC_GO,
    ST_CORDIC_WAIT,
    ST_OP,
    ST_MUL_WAIT,
    ST_WB,
    ST_DIV_WAIT,
    ST_DONE
  } ikf_state_t;

  // Per-axis micro-op sequence.
  typedef enum logic [4:0] {
    OP_NA,
    OP_GB,
    OP_TG,
    OP_QS1,
    OP_QS2,
    OP_TQ,
    OP_TP,
    OP_Q10,
    OP_TQG,
    OP_E,
    OP_K0,
    OP_K1,
    OP_KNA,
    OP_KNB,
    OP_P00,
    OP_P01,
    OP_P10,
    OP_P11
  } ikf_op_t;

  typedef struct packed {
    logic signed [63:0] val;
    logic               ovf;
  } sat_res_t;

  function automatic sat_res_t sat_wide(input logic signed [63:0] v, input int unsigned dw);
    logic signed [63:0] vmax;
    logic signed [63:0] vmin;
    sat_res_t r;
    vmax = (64'sd1 <<< (dw - 1)) - 64'sd1;
    vmin = -vmax - 64'sd1;
    r.ovf = 1'b1;
    if (v > vmax) begin
      r.val = vmax;
    end else if (v < vmin) begin
      r.val = vmin;
    end else begin
      r.val = v;
      r.ovf = 1'b0;
    end
    return r;
  endfunction

  // atan(2^-i) in degrees, 24 fraction bits
  function automatic logic [31:0] cordic_angle(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd754974720;
      5'd1:  v = 32'd445687602;
      5'd2:  v = 32'd235489088;
      5'd3:  v = 32'd119537938;
      5'd4:  v = 32'd60000934;
      5'd5:  v = 32'd30029717;
      5'd6:  v = 32'd15018523;
      5'd7:  v = 32'd7509720;
      5'd8:  v = 32'd3754917;
      5'd9:  v = 32'd1877466;
      5'd10: v = 32'd938734;
      5'd11: v = 32'd469367;
      5'd12: v = 32'd234684;
      5'd13: v = 32'd117342;
      5'd14: v = 32'd58671;
      5'd15: v = 32'd29335;
      5'd16: v = 32'd14668;
      5'd17: v = 32'd7334;
      5'd18: v = 32'd3667;
      5'd19: v = 32'd1833;
      5'd20: v = 32'd917;
      5'd21: v = 32'd458;
      5'd22: v = 32'd229;
      5'd23: v = 32'd115;
      5'd24: v = 32'd57;
      5'd25: v = 32'd29;
      5'd26: v = 32'd14;
      5'd27: v = 32'd7;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/ikf_cordic.sv */
`default_nettype none
module ikf_cordic #(
  parameter int DATA_WIDTH = ikf_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = ikf_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [ikf_pkg::ACC_WIDTH-1:0] yv,
  input  logic signed [ikf_pkg::ACC_WIDTH-1:0] xv,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] angle,
  output logic                         ovf
);
  import ikf_pkg::*;

  localparam int XW    = CORDIC_XW;
  localparam int ZW    = CORDIC_ZW;
  localparam int SHIFT = TBL_FRAC - FRAC_BITS;
  localparam int RND   = (1 << SHIFT) >> 1;

  logic signed [XW-1:0] x, y, xs, ys, dx, dy;
  logic signed [ZW-1:0] z, zr;
  logic [4:0]           cnt;
  logic                 busy;
  logic                 y_pos;
  sat_res_t             zs;

  assign xs    = {{(XW-ACC_WIDTH){xv[ACC_WIDTH-1]}}, xv};
  assign ys    = {{(XW-ACC_WIDTH){yv[ACC_WIDTH-1]}}, yv};
  assign dx    = y >>> cnt;
  assign dy    = x >>> cnt;
  assign y_pos = !y[XW-1] && (y != '0);
  assign zr    = (z + ZW'(RND)) >>> SHIFT;
  assign zs    = sat_wide({{(64-ZW){zr[ZW-1]}}, zr}, DATA_WIDTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        if (xv == '0 && yv == '0) begin
          // zero vector: skip the rotations, angle stays 0
          cnt <= 5'(CORDIC_STEPS);
          z   <= '0;
        end else begin
          cnt <= '0;
          if (xv[ACC_WIDTH-1]) begin
            x <= (-xs) <<< CORDIC_PRESHIFT;
            y <= (-ys) <<< CORDIC_PRESHIFT;
            z <= yv[ACC_WIDTH-1] ? -(ZW'(180) << TBL_FRAC) : (ZW'(180) << TBL_FRAC);
          end else begin
            x <= xs <<< CORDIC_PRESHIFT;
            y <= ys <<< CORDIC_PRESHIFT;
            z <= '0;
          end
        end
      end else if (busy) begin
        if (cnt == 5'(CORDIC_STEPS)) begin
          busy  <= 1'b0;
          done  <= 1'b1;
          angle <= zs.val[DATA_WIDTH-1:0];
          ovf   <= zs.ovf;
        end else begin
          cnt <= cnt + 5'd1;
          if (y_pos) begin
            x <= x + dx;
            y <= y - dy;
            z <= z + ZW'(cordic_angle(cnt));
          end else begin
            x <= x - dx;
            y <= y + dy;
            z <= z - ZW'(cordic_angle(cnt));
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/ikf_mul.sv */
`default_nettype none
module ikf_mul #(
  parameter int DATA_WIDTH = ikf_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = ikf_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [DATA_WIDTH-1:0] a,
  input  logic signed [DATA_WIDTH-1:0] b,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] prod,
  output logic                         ovf
);
  import ikf_pkg::*;

  localparam int CHUNK = 16;
  localparam int NCH   = (DATA_WIDTH + CHUNK - 1) / CHUNK;
  localparam int PW    = NCH * CHUNK;
  localparam int AW    = DATA_WIDTH + PW;
  localparam int CW    = $clog2(NCH + 1);

  logic [DATA_WIDTH-1:0]       am, bm, xm;
  logic [PW-1:0]               yp;
  logic [AW-1:0]               acc, rsum, rl, lim;
  logic [DATA_WIDTH+CHUNK-1:0] pp;
  logic [CW-1:0]               cnt;
  logic                        neg, busy, big;

  assign am   = a[DATA_WIDTH-1] ? -a : a;
  assign bm   = b[DATA_WIDTH-1] ? -b : b;
  // one DATA_WIDTH x 16 partial product per cycle, top chunk first
  assign pp   = (DATA_WIDTH+CHUNK)'(xm) * (DATA_WIDTH+CHUNK)'(yp[PW-1 -: CHUNK]);
  assign rsum = acc + (AW'(1) << (FRAC_BITS - 1));
  assign rl   = rsum >> FRAC_BITS;
  assign lim  = neg ? (AW'(1) << (DATA_WIDTH - 1)) : ((AW'(1) << (DATA_WIDTH - 1)) - AW'(1));
  assign big  = rl > lim;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        xm   <= am;
        yp   <= PW'(bm);
        acc  <= '0;
        neg  <= a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (cnt == CW'(NCH)) begin
          busy <= 1'b0;
          done <= 1'b1;
          ovf  <= big;
          if (big) begin
            prod <= neg ? {1'b1, {(DATA_WIDTH-1){1'b0}}} : {1'b0, {(DATA_WIDTH-1){1'b1}}};
          end else begin
            prod <= neg ? -rl[DATA_WIDTH-1:0] : rl[DATA_WIDTH-1:0];
          end
        end else begin
          acc <= (acc << CHUNK) + AW'(pp);
          yp  <= yp << CHUNK;
          cnt <= cnt + CW'(1);
        end
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/ikf_div.sv */
`default_nettype none
module ikf_div #(
  parameter int DATA_WIDTH = ikf_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = ikf_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [DATA_WIDTH-1:0] num,
  input  logic signed [DATA_WIDTH-1:0] den,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] quot,
  output logic                         ovf
);
  import ikf_pkg::*;

  localparam int NW = DATA_WIDTH + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic [DATA_WIDTH-1:0] nm, dm, d;
  logic [NW-1:0]         quo, lim;
  logic [DATA_WIDTH:0]   rem, trial;
  logic [CW-1:0]         cnt;
  logic                  neg, busy, fits, big;

  assign nm    = num[DATA_WIDTH-1] ? -num : num;
  assign dm    = den[DATA_WIDTH-1] ? -den : den;
  assign trial = {rem[DATA_WIDTH-1:0], quo[NW-1]};
  assign fits  = trial >= {1'b0, d};
  assign lim   = neg ? (NW'(1) << (DATA_WIDTH - 1)) : ((NW'(1) << (DATA_WIDTH - 1)) - NW'(1));
  assign big   = quo > lim;

  // restoring division of (|num| << FRAC_BITS) by |den|, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo  <= {nm, {FRAC_BITS{1'b0}}};
        d    <= dm;
        rem  <= '0;
        neg  <= num[DATA_WIDTH-1] ^ den[DATA_WIDTH-1];
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (cnt == CW'(NW)) begin
          busy <= 1'b0;
          done <= 1'b1;
          ovf  <= big;
          if (big) begin
            quot <= neg ? {1'b1, {(DATA_WIDTH-1){1'b0}}} : {1'b0, {(DATA_WIDTH-1){1'b1}}};
          end else begin
            quot <= neg ? -quo[DATA_WIDTH-1:0] : quo[DATA_WIDTH-1:0];
          end
        end else begin
          rem <= fits ? (trial - {1'b0, d}) : trial;
          quo <= {quo[NW-2:0], fits};
          cnt <= cnt + CW'(1);
        end
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/imu_kalman_tilt_filter_unit.sv */
// Per input transaction: three CORDIC runs (the rotations are skipped when an accelerometer
// pair is zero), then per axis six adds, ten multiplies and two divides (a divide is skipped
// when the gain denominator is zero). A new sample is accepted only in idle, after the
// previous result has been loaded, so a stalled result holds off the next sample.
// Reset clears filter state, config registers to defaults and all handshake state.
`default_nettype none
module imu_kalman_tilt_filter_unit #(
  parameter int DATA_WIDTH = ikf_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = ikf_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [ikf_pkg::ACC_WIDTH-1:0]   acc_x,
  input  logic signed [ikf_pkg::ACC_WIDTH-1:0]   acc_y,
  input  logic signed [ikf_pkg::ACC_WIDTH-1:0]   acc_z,
  input  logic signed [ikf_pkg::GYRO_WIDTH-1:0]  gyro_x,
  input  logic signed [ikf_pkg::GYRO_WIDTH-1:0]  gyro_y,
  input  logic signed [ikf_pkg::GYRO_WIDTH-1:0]  gyro_z,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [ikf_pkg::OUT_WIDTH-1:0]   angle_x,
  output logic signed [ikf_pkg::OUT_WIDTH-1:0]   angle_y,
  output logic signed [ikf_pkg::OUT_WIDTH-1:0]   angle_z,
  output logic                                   saturated,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [ikf_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [ikf_pkg::CFG_DATA_W-1:0]         cfg_data
);
  import ikf_pkg::*;
  `include "imu_kalman_tilt_filter_unit_assert.svh"

  localparam int DW = DATA_WIDTH;

  function automatic logic signed [63:0] sx64(input logic signed [DW-1:0] v);
    return {{(64-DW){v[DW-1]}}, v};
  endfunction

  ikf_state_t state, state_next;
  ikf_op_t    op, op_inc;

  logic [PERIOD_W-1:0] period;
  logic [NOISE_W-1:0]  angle_q, bias_q, measure_r;

  logic signed [ACC_WIDTH-1:0] ax_s, ay_s, az_s;
  logic signed [DW-1:0] gyr   [3];
  logic signed [DW-1:0] meas  [3];
  logic signed [DW-1:0] est_a [3];
  logic signed [DW-1:0] est_b [3];
  logic signed [DW-1:0] p00   [3];
  logic signed [DW-1:0] p01   [3];
  logic signed [DW-1:0] p10   [3];
  logic signed [DW-1:0] p11   [3];
  logic signed [DW-1:0] na, tmp, q00, q01, q10, q11, e, k0, k1;
  logic [1:0] ax, cidx;
  logic       sat_flag;

  sat_res_t t_c, qa_c, qg_c, ra_c, gx_c, gy_c, gz_c, add_res, ox, oy, oz;
  logic signed [DW-1:0] t_v, qa_v, qg_v, ra_v;
  logic signed [DW-1:0] add_a, add_b, mul_a, mul_b, div_num, add_val;
  logic signed [63:0]   sum64;
  logic add_sub, is_mul, is_div, accept, wr_add, div_zero, last_op, out_load;

  logic                 cor_start, cor_done, cor_ovf;
  logic signed [ACC_WIDTH-1:0] cor_y, cor_x;
  logic signed [DW-1:0] cor_angle;
  logic                 mul_start, mul_done, mul_ovf;
  logic signed [DW-1:0] mul_prod;
  logic                 div_start, div_done, div_ovf;
  logic signed [DW-1:0] div_q;

  assign cfg_ready = 1'b1;

  // register values clamped to the word range
  assign t_c  = sat_wide({{(64-PERIOD_W){1'b0}}, period}, DW);
  assign qa_c = sat_wide({{(64-NOISE_W){1'b0}}, angle_q}, DW);
  assign qg_c = sat_wide({{(64-NOISE_W){1'b0}}, bias_q}, DW);
  assign ra_c = sat_wide({{(64-NOISE_W){1'b0}}, measure_r}, DW);
  assign t_v  = t_c.val[DW-1:0];
  assign qa_v = qa_c.val[DW-1:0];
  assign qg_v = qg_c.val[DW-1:0];
  assign ra_v = ra_c.val[DW-1:0];

  assign gx_c = sat_wide({{(64-GYRO_WIDTH){gyro_x[GYRO_WIDTH-1]}}, gyro_x}, DW);
  assign gy_c = sat_wide({{(64-GYRO_WIDTH){gyro_y[GYRO_WIDTH-1]}}, gyro_y}, DW);
  assign gz_c = sat_wide({{(64-GYRO_WIDTH){gyro_z[GYRO_WIDTH-1]}}, gyro_z}, DW);

  assign ox = sat_wide(sx64(est_a[0]), OUT_WIDTH);
  assign oy = sat_wide(sx64(est_a[1]), OUT_WIDTH);
  assign oz = sat_wide(sx64(est_a[2]), OUT_WIDTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      period    <= PERIOD_RST;
      angle_q   <= ANGLE_Q_RST;
      bias_q    <= BIAS_Q_RST;
      measure_r <= MEASURE_R_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PERIOD:    period    <= cfg_data[PERIOD_W-1:0];
        REG_ANGLE_Q:   angle_q   <= cfg_data[NOISE_W-1:0];
        REG_BIAS_Q:    bias_q    <= cfg_data[NOISE_W-1:0];
        REG_MEASURE_R: measure_r <= cfg_data[NOISE_W-1:0];
        default: ;
      endcase
    end
  end

  // operand routing for the shared adder, multiplier and divider
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    div_num = '0;
    is_mul  = 1'b0;
    is_div  = 1'b0;
    unique case (op)
      OP_NA:  begin add_a = meas[ax];  add_b = est_a[ax]; add_sub = 1'b1; end
      OP_GB:  begin add_a = gyr[ax];   add_b = est_b[ax]; end
      OP_TG:  begin
        mul_a = t_v; mul_b = tmp; is_mul = 1'b1;
        add_a = est_a[ax]; add_b = mul_prod; add_sub = 1'b1;
      end
      OP_QS1: begin add_a = qa_v; add_b = p10[ax]; add_sub = 1'b1; end
      OP_QS2: begin add_a = tmp;  add_b = p01[ax]; add_sub = 1'b1; end
      OP_TQ:  begin
        mul_a = t_v; mul_b = tmp; is_mul = 1'b1;
        add_a = p00[ax]; add_b = mul_prod;
      end
      OP_TP:  begin
        mul_a = t_v; mul_b = p11[ax]; is_mul = 1'b1;
        add_a = p01[ax]; add_b = mul_prod; add_sub = 1'b1;
      end
      // reuses the T*p11 product still held by the multiplier
      OP_Q10: begin add_a = p10[ax]; add_b = mul_prod; add_sub = 1'b1; end
      OP_TQG: begin
        mul_a = t_v; mul_b = qg_v; is_mul = 1'b1;
        add_a = p11[ax]; add_b = mul_prod;
      end
      OP_E:   begin add_a = q00; add_b = ra_v; end
      OP_K0:  begin div_num = q00; is_div = 1'b1; end
      OP_K1:  begin div_num = q10; is_div = 1'b1; end
      OP_KNA: begin
        mul_a = k0; mul_b = na; is_mul = 1'b1;
        add_a = est_a[ax]; add_b = mul_prod;
      end
      OP_KNB: begin
        mul_a = k1; mul_b = na; is_mul = 1'b1;
        add_a = est_b[ax]; add_b = mul_prod;
      end
      OP_P00: begin
        mul_a = k0; mul_b = q00; is_mul = 1'b1;
        add_a = q00; add_b = mul_prod; add_sub = 1'b1;
      end
      OP_P01: begin
        mul_a = k0; mul_b = q01; is_mul = 1'b1;
        add_a = q01; add_b = mul_prod; add_sub = 1'b1;
      end
      OP_P10: begin
        mul_a = k1; mul_b = q00; is_mul = 1'b1;
        add_a = q10; add_b = mul_prod; add_sub = 1'b1;
      end
      OP_P11: begin
        mul_a = k1; mul_b = q01; is_mul = 1'b1;
        add_a = q11; add_b = mul_prod; add_sub = 1'b1;
      end
      default: ;
    endcase
  end

  assign sum64   = add_sub ? (sx64(add_a) - sx64(add_b)) : (sx64(add_a) + sx64(add_b));
  assign add_res = sat_wide(sum64, DW);
  assign add_val = add_res.val[DW-1:0];

  assign op_inc   = ikf_op_t'(op + 5'd1);
  assign accept   = in_valid && !in_stall;
  assign wr_add   = (state == ST_OP && !is_mul && !is_div) || (state == ST_WB);
  assign div_zero = (e == '0);
  assign last_op  = (op == OP_P11) && (ax == 2'd2);
  assign out_load = (state == ST_DONE) && (!out_valid || !out_stall);

  always_comb begin
    unique case (cidx)
      2'd0:    begin cor_y = ay_s; cor_x = az_s; end
      2'd1:    begin cor_y = ax_s; cor_x = az_s; end
      default: begin cor_y = ax_s; cor_x = ay_s; end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:        if (in_valid) state_next = ST_CORDIC_GO;
      ST_CORDIC_GO:   state_next = ST_CORDIC_WAIT;
      ST_CORDIC_WAIT: if (cor_done) state_next = (cidx == 2'd2) ? ST_OP : ST_CORDIC_GO;
      ST_OP: begin
        if (is_mul) begin
          state_next = ST_MUL_WAIT;
        end else if (is_div && !div_zero) begin
          state_next = ST_DIV_WAIT;
        end
      end
      ST_MUL_WAIT:    if (mul_done) state_next = ST_WB;
      ST_WB:          state_next = last_op ? ST_DONE : ST_OP;
      ST_DIV_WAIT:    if (div_done) state_next = ST_OP;
      ST_DONE:        if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:        state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != ST_IDLE);
    cor_start = (state == ST_CORDIC_GO);
    mul_start = (state == ST_OP) && is_mul;
    div_start = (state == ST_OP) && is_div && !div_zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        est_a[k] <= '0;
        est_b[k] <= '0;
        p00[k]   <= '0;
        p01[k]   <= '0;
        p10[k]   <= '0;
        p11[k]   <= '0;
      end
      ax       <= '0;
      cidx     <= '0;
      op       <= OP_NA;
      sat_flag <= 1'b0;
    end else begin
      if (accept) begin
        ax_s     <= acc_x;
        ay_s     <= acc_y;
        az_s     <= acc_z;
        gyr[0]   <= gx_c.val[DW-1:0];
        gyr[1]   <= gy_c.val[DW-1:0];
        gyr[2]   <= gz_c.val[DW-1:0];
        sat_flag <= gx_c.ovf | gy_c.ovf | gz_c.ovf |
                    t_c.ovf | qa_c.ovf | qg_c.ovf | ra_c.ovf;
        ax       <= '0;
        cidx     <= '0;
        op       <= OP_NA;
      end
      if (state == ST_CORDIC_WAIT && cor_done) begin
        meas[cidx] <= cor_angle;
        sat_flag   <= sat_flag | cor_ovf;
        cidx       <= cidx + 2'd1;
      end
      if (wr_add) begin
        sat_flag <= sat_flag | add_res.ovf | ((state == ST_WB) && mul_ovf);
        case (op)
          OP_NA:  na        <= add_val;
          OP_GB:  tmp       <= add_val;
          OP_TG:  est_a[ax] <= add_val;
          OP_QS1: tmp       <= add_val;
          OP_QS2: tmp       <= add_val;
          OP_TQ:  q00       <= add_val;
          OP_TP:  q01       <= add_val;
          OP_Q10: q10       <= add_val;
          OP_TQG: q11       <= add_val;
          OP_E:   e         <= add_val;
          OP_KNA: est_a[ax] <= add_val;
          OP_KNB: est_b[ax] <= add_val;
          OP_P00: p00[ax]   <= add_val;
          OP_P01: p01[ax]   <= add_val;
          OP_P10: p10[ax]   <= add_val;
          OP_P11: p11[ax]   <= add_val;
          default: ;
        endcase
      end
      // zero denominator gives zero gains
      if (state == ST_OP && is_div && div_zero) begin
        if (op == OP_K0) k0 <= '0;
        else             k1 <= '0;
      end
      if (state == ST_DIV_WAIT && div_done) begin
        sat_flag <= sat_flag | div_ovf;
        if (op == OP_K0) k0 <= div_q;
        else             k1 <= div_q;
      end
      if (wr_add || (state == ST_OP && is_div && div_zero) ||
          (state == ST_DIV_WAIT && div_done)) begin
        if (op == OP_P11) begin
          op <= OP_NA;
          ax <= (ax == 2'd2) ? 2'd0 : ax + 2'd1;
        end else begin
          op <= op_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
      angle_x   <= ox.val[OUT_WIDTH-1:0];
      angle_y   <= oy.val[OUT_WIDTH-1:0];
      angle_z   <= oz.val[OUT_WIDTH-1:0];
      saturated <= sat_flag | ox.ovf | oy.ovf | oz.ovf;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  ikf_cordic #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_cordic (
    .clk  (clk),
    .rst  (rst),
    .start(cor_start),
    .yv   (cor_y),
    .xv   (cor_x),
    .done (cor_done),
    .angle(cor_angle),
    .ovf  (cor_ovf)
  );

  ikf_mul #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .prod (mul_prod),
    .ovf  (mul_ovf)
  );

  ikf_div #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (e),
    .done (div_done),
    .quot (div_q),
    .ovf  (div_ovf)
  );

  `IKF_ASSERT_NEXT(a_busy_after_accept, clk, rst, accept, in_stall, "accepted sample did not block the input")
  `IKF_ASSERT_NEXT(a_result_loaded, clk, rst, out_load, out_valid, "finished sample not presented")
  `IKF_ASSERT_SAME(a_mul_done_owner, clk, rst, mul_done, state == ST_MUL_WAIT, "multiplier finished outside its wait")
  `IKF_ASSERT_SAME(a_div_den_nonzero, clk, rst, div_start, e != '0, "divider started with zero denominator")

endmodule
`default_nettype wire
